// ===== hw/rtl/free_list_segment_allocator_unit_macros.svh =====
// Assertion macros shared by the allocator's checker.
// Depends on nothing.
`ifndef FREE_LIST_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_LIST_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH

// Implication checked every clock outside reset.
`define FLSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FLSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/flsa_pkg.sv =====
// Package for the free list segment allocator: widths, codes, state type.
// Depends on nothing.
package flsa_pkg;
   localparam int FREE_SLOTS_DEF    = 16;
   localparam int BLOCK_SLOTS_DEF   = 32;
   localparam int ADDR_BITS_DEF     = 20;
   localparam int ALIGN_BYTES_DEF   = 8;
   localparam int HEADER_BYTES_DEF  = 24;
   localparam int CONTROL_BYTES_DEF = 24;

   localparam int FIELD_BITS = 20;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MEMORY_BYTES = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_POLICY   = 1'd1;

   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_BAD     = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_SCAN,   // walk free table choosing a segment
      S_A_SLOT,   // walk block table for an empty slot
      S_A_RD,     // read chosen segment
      S_A_UPD,    // shrink or remove it
      S_F_FIND,   // walk block table for the start
      S_F_POS,    // walk free table for the insert point
      S_F_NEXT,   // read the following segment
      S_F_UPD,    // decide merge
      S_SHL,      // shift entries down (remove)
      S_SHR,      // shift entries up (insert)
      S_DONE
   } state_type;
endpackage

// ===== hw/rtl/free_list_segment_allocator_unit.sv =====
// Free list segment allocator, top level: sequencer, block table, registers.
// An alloc scans the free table, then the block table for an empty slot; an exact fit
// removes the segment by shifting entries down. A free searches the block table, then
// the free table for the insert point; a merge with both neighbours shifts entries
// down and an insert shifts them up. One item at a time: busy stays high through the
// result strobe. Synchronous reset empties both tables.
// Depends on flsa_pkg and flsa_free_table.
module free_list_segment_allocator_unit #(
   parameter int FREE_SLOTS    = flsa_pkg::FREE_SLOTS_DEF,
   parameter int BLOCK_SLOTS   = flsa_pkg::BLOCK_SLOTS_DEF,
   parameter int ADDR_BITS     = flsa_pkg::ADDR_BITS_DEF,
   parameter int ALIGN_BYTES   = flsa_pkg::ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES  = flsa_pkg::HEADER_BYTES_DEF,
   parameter int CONTROL_BYTES = flsa_pkg::CONTROL_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [flsa_pkg::FIELD_BITS-1:0] req_request_bytes,
   input  logic [flsa_pkg::FIELD_BITS-1:0] req_block_offset,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [flsa_pkg::FIELD_BITS-1:0] rsp_result_offset,
   output logic [flsa_pkg::FIELD_BITS-1:0] rsp_result_bytes,
   input  logic        csr_write,
   input  logic [flsa_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [flsa_pkg::FIELD_BITS-1:0]   csr_data
);
   localparam int FB  = flsa_pkg::FIELD_BITS;
   localparam int AW  = ADDR_BITS + 2;            // room for sums before truncation
   localparam int FI  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int FC  = $clog2(FREE_SLOTS + 1);
   localparam int BI  = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
   localparam int BC  = $clog2(BLOCK_SLOTS + 1);
   localparam logic [AW-1:0] ALIGN_M1 = AW'(ALIGN_BYTES - 1);
   localparam logic [AW-1:0] HDR      = AW'(HEADER_BYTES);
   localparam logic [AW-1:0] CTRL     = AW'(CONTROL_BYTES);
   localparam logic [AW-1:0] AMASK    = AW'((64'd1 << ADDR_BITS) - 1);

   flsa_pkg::state_type state_ff, state_in;

   logic [FB-1:0] mem_bytes_ff;
   logic [1:0]    fit_ff;

   logic [FC-1:0] fcount_ff, fcount_in;
   logic [BLOCK_SLOTS-1:0] uvalid_ff, uvalid_in;
   logic [AW-1:0] ustart_mem [BLOCK_SLOTS];
   logic [AW-1:0] ulen_mem   [BLOCK_SLOTS];
   logic [AW-1:0] u_rd_start, u_rd_len;
   logic          u_wr;
   logic [BI-1:0] u_rd_idx;

   logic [1:0]    act_ff, act_in;
   logic [AW-1:0] need_ff, need_in;     // alloc size, or freed block length
   logic [AW-1:0] bstart_ff, bstart_in; // block start
   logic [FC-1:0] fi_ff, fi_in;         // free table walk index
   logic [BC-1:0] bi_ff, bi_in;         // block table walk index
   logic          rvalid_ff, rvalid_in; // read data of previous index is live
   logic          pick_ok_ff, pick_ok_in;
   logic [FI-1:0] pick_ff, pick_in;
   logic [AW-1:0] pick_len_ff, pick_len_in;
   logic [BI-1:0] slot_ff, slot_in;
   logic [AW-1:0] pend_ff, pend_in;     // end of previous segment
   logic          prev_ok_ff, prev_ok_in;
   logic [FC-1:0] sh_ff, sh_in;         // shift cursor
   logic [FC-1:0] sh_end_ff, sh_end_in;
   logic          merge_both_ff, merge_both_in;
   logic [AW-1:0] plen_ff, plen_in;     // previous segment length
   logic [2:0]    st_ff, st_in;
   logic [AW-1:0] roff_ff, roff_in;
   logic [AW-1:0] rbytes_ff, rbytes_in;

   logic          f_wr;
   logic [FI-1:0] f_wr_idx, f_rd_idx;
   logic [AW-1:0] f_wr_start, f_wr_len;
   logic [ADDR_BITS-1:0] f_rd_start_n, f_rd_len_n;
   logic [AW-1:0] f_rd_start, f_rd_len;

   flsa_free_table #(.FREE_SLOTS(FREE_SLOTS), .ADDR_BITS(ADDR_BITS)) u_table (
      .clock    (clock),
      .wr_en    (f_wr),
      .wr_idx   (f_wr_idx),
      .wr_start (f_wr_start[ADDR_BITS-1:0]),
      .wr_len   (f_wr_len[ADDR_BITS-1:0]),
      .rd_idx   (f_rd_idx),
      .rd_start (f_rd_start_n),
      .rd_len   (f_rd_len_n)
   );
   assign f_rd_start = AW'(f_rd_start_n);
   assign f_rd_len   = AW'(f_rd_len_n);

   always_ff @(posedge clock) begin
      if (u_wr) begin
         ustart_mem[slot_ff] <= bstart_ff;
         ulen_mem[slot_ff]   <= need_ff;
      end
      u_rd_start <= ustart_mem[u_rd_idx];
      u_rd_len   <= ulen_mem[u_rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flsa_pkg::S_IDLE;
         mem_bytes_ff <= FB'(1048575);
         fit_ff       <= flsa_pkg::FIT_FIRST;
         fcount_ff    <= '0;
         uvalid_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         fcount_ff <= fcount_in;
         uvalid_ff <= uvalid_in;
         if (csr_write) begin
            case (csr_index)
               flsa_pkg::CSR_MEMORY_BYTES: mem_bytes_ff <= csr_data;
               flsa_pkg::CSR_FIT_POLICY:   fit_ff <= csr_data[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;       need_ff <= need_in;     bstart_ff <= bstart_in;
      fi_ff <= fi_in;         bi_ff <= bi_in;         rvalid_ff <= rvalid_in;
      pick_ok_ff <= pick_ok_in; pick_ff <= pick_in;   pick_len_ff <= pick_len_in;
      slot_ff <= slot_in;     pend_ff <= pend_in;     prev_ok_ff <= prev_ok_in;
      sh_ff <= sh_in;         sh_end_ff <= sh_end_in; merge_both_ff <= merge_both_in;
      plen_ff <= plen_in;     st_ff <= st_in;         roff_ff <= roff_in;
      rbytes_ff <= rbytes_in;
   end

   // next state
   logic [AW-1:0] need_raw;
   logic [AW-1:0] rd_idx_prev_end;
   logic          fit_ok, better;
   assign need_raw = ((AW'(req_request_bytes) + HDR + ALIGN_M1) / AW'(ALIGN_BYTES))
                     * AW'(ALIGN_BYTES);
   assign rd_idx_prev_end = (f_rd_start + f_rd_len) & AMASK;
   assign fit_ok = f_rd_len >= need_ff;
   always_comb begin
      case (fit_ff)
         flsa_pkg::FIT_BEST:  better = !pick_ok_ff || f_rd_len < pick_len_ff;
         flsa_pkg::FIT_WORST: better = !pick_ok_ff || f_rd_len > pick_len_ff;
         default:             better = !pick_ok_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff; need_in = need_ff; bstart_in = bstart_ff;
      fi_in = fi_ff; bi_in = bi_ff; rvalid_in = 1'b0;
      pick_ok_in = pick_ok_ff; pick_in = pick_ff; pick_len_in = pick_len_ff;
      slot_in = slot_ff; pend_in = pend_ff; prev_ok_in = prev_ok_ff;
      sh_in = sh_ff; sh_end_in = sh_end_ff; merge_both_in = merge_both_ff;
      plen_in = plen_ff; st_in = st_ff; roff_in = roff_ff; rbytes_in = rbytes_ff;
      fcount_in = fcount_ff; uvalid_in = uvalid_ff;
      f_wr = 1'b0; f_wr_idx = '0; f_wr_start = '0; f_wr_len = '0;
      f_rd_idx = fi_ff[FI-1:0];
      u_wr = 1'b0; u_rd_idx = bi_ff[BI-1:0];
      case (state_ff)
         flsa_pkg::S_IDLE: begin
            if (start) begin
               act_in = req_action; st_in = flsa_pkg::ST_OK;
               roff_in = '0; rbytes_in = '0;
               fi_in = '0; bi_in = '0; pick_ok_in = 1'b0; prev_ok_in = 1'b0;
               need_in = need_raw;
               bstart_in = AW'(req_block_offset);
               case (req_action)
                  flsa_pkg::ACT_INIT: begin
                     uvalid_in = '0;
                     fcount_in = '0;
                     if (AW'(mem_bytes_ff) > CTRL) begin
                        f_wr = 1'b1; f_wr_idx = '0; f_wr_start = CTRL;
                        f_wr_len = AW'(mem_bytes_ff) - CTRL;
                        fcount_in = FC'(1);
                     end
                     state_in = flsa_pkg::S_DONE;
                  end
                  flsa_pkg::ACT_ALLOC: begin
                     if (req_request_bytes == '0 || req_request_bytes >= mem_bytes_ff) begin
                        st_in = flsa_pkg::ST_BAD; state_in = flsa_pkg::S_DONE;
                     end else state_in = flsa_pkg::S_A_SCAN;
                  end
                  flsa_pkg::ACT_FREE: state_in = flsa_pkg::S_F_FIND;
                  default: begin
                     st_in = flsa_pkg::ST_BAD; state_in = flsa_pkg::S_DONE;
                  end
               endcase
            end
         end
         flsa_pkg::S_A_SCAN: begin
            // read index fi issued now; data of fi-1 evaluated when rvalid
            if (rvalid_ff && fit_ok && better) begin
               pick_ok_in = 1'b1; pick_in = FI'(fi_ff - FC'(1)); pick_len_in = f_rd_len;
            end
            if (rvalid_ff && fit_ok && (fit_ff != flsa_pkg::FIT_BEST)
                && (fit_ff != flsa_pkg::FIT_WORST)) begin
               state_in = flsa_pkg::S_A_SLOT;
            end else if (fi_ff >= fcount_ff) begin
               if (!rvalid_ff) begin
                  state_in = (pick_ok_ff) ? flsa_pkg::S_A_SLOT : flsa_pkg::S_DONE;
                  if (!pick_ok_ff) st_in = flsa_pkg::ST_NOFIT;
               end
            end else begin
               fi_in = fi_ff + FC'(1); rvalid_in = 1'b1;
            end
            if (fi_ff >= fcount_ff && rvalid_ff && !(fit_ok &&
                (fit_ff != flsa_pkg::FIT_BEST) && (fit_ff != flsa_pkg::FIT_WORST)))
               state_in = flsa_pkg::S_A_SCAN;
            bi_in = '0;
         end
         flsa_pkg::S_A_SLOT: begin
            if (!uvalid_ff[bi_ff[BI-1:0]]) begin
               slot_in = bi_ff[BI-1:0]; state_in = flsa_pkg::S_A_RD;
            end else if (bi_ff == BC'(BLOCK_SLOTS - 1)) begin
               st_in = flsa_pkg::ST_FULL; state_in = flsa_pkg::S_DONE;
            end else bi_in = bi_ff + BC'(1);
            f_rd_idx = pick_ff;
         end
         flsa_pkg::S_A_RD: begin
            f_rd_idx = pick_ff;
            state_in = flsa_pkg::S_A_UPD;
         end
         flsa_pkg::S_A_UPD: begin
            bstart_in = f_rd_start;
            roff_in = f_rd_start; rbytes_in = need_ff;
            uvalid_in[slot_ff] = 1'b1;
            if (f_rd_len == need_ff) begin
               sh_in = FC'(pick_ff); sh_end_in = fcount_ff - FC'(1);
               fcount_in = fcount_ff - FC'(1);
               state_in = flsa_pkg::S_SHL;
            end else begin
               f_wr = 1'b1; f_wr_idx = pick_ff;
               f_wr_start = (f_rd_start + need_ff) & AMASK;
               f_wr_len = f_rd_len - need_ff;
               state_in = flsa_pkg::S_DONE;
            end
         end
         flsa_pkg::S_F_FIND: begin
            // used table read is registered; check previous index
            if (rvalid_ff && uvalid_ff[slot_ff] && u_rd_start == bstart_ff) begin
               need_in = u_rd_len; state_in = flsa_pkg::S_F_POS; fi_in = '0;
            end else if (bi_ff == BC'(BLOCK_SLOTS)) begin
               st_in = flsa_pkg::ST_UNKNOWN; state_in = flsa_pkg::S_DONE;
            end else begin
               slot_in = bi_ff[BI-1:0]; bi_in = bi_ff + BC'(1); rvalid_in = 1'b1;
            end
            u_rd_idx = (bi_ff == BC'(BLOCK_SLOTS)) ? '0 : bi_ff[BI-1:0];
         end
         flsa_pkg::S_F_POS: begin
            if (rvalid_ff && f_rd_start < bstart_ff) begin
               prev_ok_in = 1'b1; pend_in = rd_idx_prev_end; plen_in = f_rd_len;
            end
            if (rvalid_ff && !(f_rd_start < bstart_ff)) begin
               fi_in = fi_ff - FC'(1); state_in = flsa_pkg::S_F_NEXT;
            end else if (fi_ff >= fcount_ff) begin
               state_in = flsa_pkg::S_F_NEXT;
            end else begin
               fi_in = fi_ff + FC'(1); rvalid_in = 1'b1;
            end
         end
         flsa_pkg::S_F_NEXT: begin
            // fi is now the insert position; fetch it
            state_in = flsa_pkg::S_F_UPD;
         end
         flsa_pkg::S_F_UPD: begin
            automatic logic jp = prev_ok_ff && pend_ff == bstart_ff;
            automatic logic jn = fi_ff < fcount_ff &&
                                 ((bstart_ff + need_ff) & AMASK) == f_rd_start;
            rbytes_in = need_ff;
            state_in = flsa_pkg::S_DONE;
            if (jp && jn) begin
               f_wr = 1'b1; f_wr_idx = FI'(fi_ff - FC'(1));
               f_wr_start = (pend_ff - plen_ff) & AMASK;
               f_wr_len = (plen_ff + need_ff + f_rd_len) & AMASK;
               sh_in = fi_ff; sh_end_in = fcount_ff - FC'(1);
               fcount_in = fcount_ff - FC'(1);
               state_in = flsa_pkg::S_SHL;
               uvalid_in[slot_ff] = 1'b0;
            end else if (jp) begin
               f_wr = 1'b1; f_wr_idx = FI'(fi_ff - FC'(1));
               f_wr_start = (pend_ff - plen_ff) & AMASK;
               f_wr_len = (plen_ff + need_ff) & AMASK;
               uvalid_in[slot_ff] = 1'b0;
            end else if (jn) begin
               f_wr = 1'b1; f_wr_idx = FI'(fi_ff);
               f_wr_start = bstart_ff;
               f_wr_len = (f_rd_len + need_ff) & AMASK;
               uvalid_in[slot_ff] = 1'b0;
            end else if (fcount_ff >= FC'(FREE_SLOTS)) begin
               st_in = flsa_pkg::ST_FULL; rbytes_in = '0;
            end else begin
               uvalid_in[slot_ff] = 1'b0;
               sh_in = fcount_ff; sh_end_in = fi_ff;
               fcount_in = fcount_ff + FC'(1);
               state_in = flsa_pkg::S_SHR; rvalid_in = 1'b0;
            end
         end
         flsa_pkg::S_SHL: begin
            // move entry sh+1 to sh: read it, then write it from the registered read data
            f_rd_idx = FI'(sh_ff + FC'(1));
            if (rvalid_ff) begin
               f_wr = 1'b1; f_wr_idx = FI'(sh_ff);
               f_wr_start = f_rd_start; f_wr_len = f_rd_len;
               sh_in = sh_ff + FC'(1);
               f_rd_idx = FI'(sh_ff + FC'(2));
            end
            if (rvalid_ff ? (sh_ff + FC'(1) >= sh_end_ff) : (sh_ff >= sh_end_ff))
               state_in = flsa_pkg::S_DONE;
            else rvalid_in = 1'b1;
         end
         flsa_pkg::S_SHR: begin
            // move entry sh-1 to sh, then place the block at sh_end
            if (sh_ff == sh_end_ff) begin
               f_wr = 1'b1; f_wr_idx = FI'(sh_ff);
               f_wr_start = bstart_ff; f_wr_len = need_ff;
               state_in = flsa_pkg::S_DONE;
            end else begin
               f_rd_idx = FI'(sh_ff - FC'(1));
               if (rvalid_ff) begin
                  f_wr = 1'b1; f_wr_idx = FI'(sh_ff);
                  f_wr_start = f_rd_start; f_wr_len = f_rd_len;
                  sh_in = sh_ff - FC'(1);
               end else rvalid_in = 1'b1;
            end
         end
         flsa_pkg::S_DONE: begin
            // a granted block is entered once its start has settled
            u_wr = (act_ff == flsa_pkg::ACT_ALLOC) && (st_ff == flsa_pkg::ST_OK);
            state_in = flsa_pkg::S_IDLE;
         end
         default: state_in = flsa_pkg::S_IDLE;
      endcase
      if (st_in != flsa_pkg::ST_OK) begin
         roff_in = '0;
         if (state_ff != flsa_pkg::S_F_UPD) rbytes_in = '0;
      end
   end

   // outputs
   always_comb begin
      busy              = state_ff != flsa_pkg::S_IDLE;
      rsp_valid         = state_ff == flsa_pkg::S_DONE;
      rsp_status        = st_ff;
      rsp_result_offset = FB'(roff_ff & AMASK);
      rsp_result_bytes  = FB'(rbytes_ff & AMASK);
   end
endmodule

// ===== hw/rtl/flsa_free_table.sv =====
// Free segment table: start and length memories, one write and one read port.
// Depends on flsa_pkg.
module flsa_free_table #(
   parameter int FREE_SLOTS = flsa_pkg::FREE_SLOTS_DEF,
   parameter int ADDR_BITS  = flsa_pkg::ADDR_BITS_DEF,
   localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IW-1:0]        wr_idx,
   input  logic [ADDR_BITS-1:0] wr_start,
   input  logic [ADDR_BITS-1:0] wr_len,
   input  logic [IW-1:0]        rd_idx,
   output logic [ADDR_BITS-1:0] rd_start,
   output logic [ADDR_BITS-1:0] rd_len
);
   logic [ADDR_BITS-1:0] start_mem [FREE_SLOTS];
   logic [ADDR_BITS-1:0] len_mem   [FREE_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_idx] <= wr_start;
         len_mem[wr_idx]   <= wr_len;
      end
      rd_start <= start_mem[rd_idx];
      rd_len   <= len_mem[rd_idx];
   end
endmodule

// ===== hw/rtl/flsa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
// Depends on flsa_pkg and the macros header.
`include "free_list_segment_allocator_unit_macros.svh"
module flsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [flsa_pkg::FIELD_BITS-1:0] rsp_result_offset,
   input logic [flsa_pkg::FIELD_BITS-1:0] rsp_result_bytes
);
   `FLSA_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, busy, "result while idle")
   `FLSA_ASSERT_NEXT(a_one_beat, clock, reset, rsp_valid, !rsp_valid, "result held two cycles")
   `FLSA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept not busy")
   `FLSA_ASSERT_IMPL(a_err_zero, clock, reset,
      rsp_valid && rsp_status != flsa_pkg::ST_OK,
      rsp_result_offset == '0 && rsp_result_bytes == '0, "error result not zero")
endmodule

bind free_list_segment_allocator_unit flsa_checker u_flsa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_result_offset(rsp_result_offset), .rsp_result_bytes(rsp_result_bytes)
);
